// ----- hdl/stream_find_replace_assert.svh -----
// ---------------------------------------------------------------------------
// stream_find_replace assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stream_find_replace assertion failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stream_find_replace assertion failed");

`endif

// ----- hdl/sfr_pkg.sv -----
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the streaming find-and-replace block.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned MaxRepl    = 8;

  // the pattern and replacement registers hold eight bytes each
  localparam int unsigned WinDepth = (MaxPattern < 8) ? MaxPattern : 8;
  localparam int unsigned RepDepth = (MaxRepl < 8) ? MaxRepl : 8;
  localparam int unsigned BurstMax = (WinDepth > RepDepth) ? WinDepth : RepDepth;
  localparam int unsigned QDepth   = 2 * BurstMax;

  localparam int unsigned LenW    = 4;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FillW   = $clog2(WinDepth + 1);
  localparam int unsigned CntW    = $clog2(QDepth + 1);
  localparam int unsigned KW      = (BurstMax > 1) ? $clog2(BurstMax) : 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLen   = 2'd0,
    CfgPatternBytes = 2'd1,
    CfgReplLen      = 2'd2,
    CfgReplBytes    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;
  } out_item_t;

  // window cell control
  typedef struct packed {
    logic load;
    logic shift;
  } win_ctrl_t;

  // output queue cell control
  typedef struct packed {
    logic pop;
    logic load;
  } oq_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/sfr_win_cell.sv -----
// ---------------------------------------------------------------------------
// sfr_win_cell
// One byte of the match window: holds the byte, merges in the arriving byte
// and compares against its pattern byte.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_win_cell (
  input  wire                  clk_i,
  input  sfr_pkg::win_ctrl_t   ctrl_i,
  input  wire                  sel_new_i,
  input  wire  [7:0]           new_byte_i,
  input  wire  [7:0]           nbr_byte_i,
  input  wire  [7:0]           pat_byte_i,
  input  wire                  active_i,
  output logic [7:0]           eff_byte_o,
  output logic                 hit_o
);
  import sfr_pkg::*;

  logic [7:0] byte_q;

  assign eff_byte_o = sel_new_i ? new_byte_i : byte_q;
  assign hit_o      = !active_i || (eff_byte_o == pat_byte_i);

  // on a miss with a full window, the window slides toward the oldest end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      byte_q <= ctrl_i.shift ? nbr_byte_i : eff_byte_o;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_out_cell.sv -----
// ---------------------------------------------------------------------------
// sfr_out_cell
// One entry of the output queue: loads a result, or takes its neighbor's
// entry when the head is transferred out.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_out_cell (
  input  wire                  clk_i,
  input  sfr_pkg::oq_ctrl_t    ctrl_i,
  input  sfr_pkg::out_item_t   load_item_i,
  input  sfr_pkg::out_item_t   nbr_item_i,
  output sfr_pkg::out_item_t   item_o
);
  import sfr_pkg::*;

  out_item_t item_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.load) begin
      item_q <= load_item_i;
    end else if (ctrl_i.pop) begin
      item_q <= nbr_item_i;
    end else begin
      item_q <= item_q;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ----- hdl/stream_find_replace.sv -----
// ---------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over bytes: a row of window cells matches the
// pattern, and a row of queue cells buffers the rewritten bytes.
// ---------------------------------------------------------------------------
//  channel | signals                              | direction
//  input   | in_valid_i / in_ready_o / in_data_i   | in
//  output  | out_valid_o / out_ready_i / out_data_o| out
//  config  | cfg_we_i / cfg_index_i / cfg_data_i   | in, write only
//
//  an input byte's results all land in the queue at once, when the byte is accepted
//  results leave one per cycle while out_ready_i is high, in the order they were loaded
//  the 16-entry queue takes a new byte whenever it holds 8 or fewer results
//  sustained: one byte per cycle while each byte yields at most one result and the output is not stalled
//  no clearing pass after reset; output stalls hold off input once more than 8 results wait
// ---------------------------------------------------------------------------
`default_nettype none

module stream_find_replace (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  sfr_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output sfr_pkg::out_item_t               out_data_o,
  input  wire                              cfg_we_i,
  input  wire  [sfr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [sfr_pkg::CfgW-1:0]         cfg_data_i
);
  import sfr_pkg::*;

  // configuration
  logic [LenW-1:0] pat_len_q, rep_len_q;
  logic [CfgW-1:0] pat_q, rep_q;

  // window
  logic [FillW-1:0] fill_q, fill_d, fill_eff, plen;
  logic [LenW-1:0]  rlen;
  logic             full, match, accept, last;
  win_ctrl_t        win_ctrl;
  logic [7:0]       eff   [WinDepth];
  logic             hit   [WinDepth];
  logic [WinDepth-1:0] hit_vec;
  logic [7:0]       emit  [BurstMax];
  logic [LenW-1:0]  n_res;

  // output queue
  logic [CntW-1:0]  cnt_q, cnt_d, base;
  logic             pop;
  oq_ctrl_t         q_ctrl  [QDepth];
  out_item_t        q_load  [QDepth];
  out_item_t        q_item  [QDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= LenW'(1);
      pat_q     <= '0;
      rep_len_q <= LenW'(1);
      rep_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPatternLen:   pat_len_q <= cfg_data_i[LenW-1:0];
        CfgPatternBytes: pat_q     <= cfg_data_i;
        CfgReplLen:      rep_len_q <= cfg_data_i[LenW-1:0];
        CfgReplBytes:    rep_q     <= cfg_data_i;
      endcase
    end
  end

  // effective lengths: pattern length zero acts as one, both saturate
  always_comb begin
    if (pat_len_q == '0) begin
      plen = FillW'(1);
    end else if (pat_len_q > LenW'(WinDepth)) begin
      plen = FillW'(WinDepth);
    end else begin
      plen = FillW'(pat_len_q);
    end
    rlen = (rep_len_q > LenW'(RepDepth)) ? LenW'(RepDepth) : rep_len_q;
  end

  assign accept   = in_valid_i && in_ready_o;
  assign last     = in_data_i.in_last;
  assign fill_eff = (fill_q >= plen) ? '0 : fill_q;
  assign full     = (fill_eff + FillW'(1)) == plen;

  for (genvar i = 0; i < WinDepth; i++) begin : g_win
    logic [7:0] nbr;
    if (i < WinDepth - 1) begin : g_nbr
      assign nbr = eff[i+1];
    end else begin : g_end
      assign nbr = '0;
    end

    sfr_win_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (win_ctrl),
      .sel_new_i  (fill_eff == FillW'(i)),
      .new_byte_i (in_data_i.in_byte),
      .nbr_byte_i (nbr),
      .pat_byte_i (pat_q[8*i +: 8]),
      .active_i   (FillW'(i) < plen),
      .eff_byte_o (eff[i]),
      .hit_o      (hit[i])
    );

    assign hit_vec[i] = hit[i];
  end

  assign match          = &hit_vec;
  assign win_ctrl.load  = accept;
  assign win_ctrl.shift = full && !match;

  for (genvar k = 0; k < BurstMax; k++) begin : g_emit
    logic [7:0] rb, wb;
    if (k < RepDepth) begin : g_rb
      assign rb = rep_q[8*k +: 8];
    end else begin : g_rb0
      assign rb = '0;
    end
    if (k < WinDepth) begin : g_wb
      assign wb = eff[k];
    end else begin : g_wb0
      assign wb = '0;
    end
    assign emit[k] = (full && match) ? rb : wb;
  end

  // result count and next fill
  always_comb begin
    priority if (full && match) begin
      n_res  = rlen;
      fill_d = '0;
    end else if (full) begin
      n_res  = last ? LenW'(plen) : LenW'(1);
      fill_d = last ? '0 : fill_eff;
    end else begin
      n_res  = last ? LenW'(fill_eff + FillW'(1)) : '0;
      fill_d = last ? '0 : fill_eff + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CfgPatternLen) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // output queue: head at cell 0, a burst is appended behind what remains
  assign pop   = (cnt_q != '0) && out_ready_i;
  assign base  = cnt_q - CntW'(pop);
  assign cnt_d = base + (accept ? CntW'(n_res) : '0);

  always_comb begin
    logic [CntW-1:0] idx;
    for (int i = 0; i < QDepth; i++) begin
      idx = CntW'(i) - base;
      q_ctrl[i].pop  = pop;
      q_ctrl[i].load = accept && (CntW'(i) >= base) && (idx < CntW'(n_res));
      q_load[i].out_byte    = emit[idx[KW-1:0]];
      q_load[i].run_last    = (idx + CntW'(1)) == CntW'(n_res);
      q_load[i].stream_last = ((idx + CntW'(1)) == CntW'(n_res)) && last;
    end
  end

  for (genvar i = 0; i < QDepth; i++) begin : g_q
    out_item_t nbr;
    if (i < QDepth - 1) begin : g_nbr
      assign nbr = q_item[i+1];
    end else begin : g_end
      assign nbr = '0;
    end

    sfr_out_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (q_ctrl[i]),
      .load_item_i (q_load[i]),
      .nbr_item_i  (nbr),
      .item_o      (q_item[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign in_ready_o  = cnt_q <= CntW'(QDepth - BurstMax);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = q_item[0];

endmodule

`default_nettype wire

// ----- hdl/sfr_checker.sv -----
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stream_find_replace_assert.svh"

module sfr_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input sfr_pkg::out_item_t out_data_o
);
  import sfr_pkg::*;

  // an empty output side always has room for a new byte
  `SFR_ASSERT_NOW(a_empty_ready, !out_valid_o, in_ready_o)

  // results only show up after an input transfer
  `SFR_ASSERT_NEXT(a_out_needs_in, !out_valid_o && !(in_valid_i && in_ready_o), !out_valid_o)

  // end of stream closes a run
  `SFR_ASSERT_NOW(a_stream_run, out_valid_o && out_data_o.stream_last, out_data_o.run_last)

  // a stalled result holds
  `SFR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench for stream_find_replace
// Walks a short table of directed bytes and register writes, then random
// streams built around the configured pattern. Every accepted byte runs
// through a behavioral rewrite predictor. Each output transfer is compared
// with the oldest expected byte; both channels stall in random bursts but in the steady last phase.
// ---------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;

  localparam int unsigned QuietCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 52;
  localparam int unsigned NumPhases   = 7;

  typedef enum logic {RowWrite, RowByte} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    cfg_idx_e   reg_idx;
    logic [63:0] value;
    in_item_t   item;
    logic       pinned;
    out_item_t  result;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_index = CfgPatternLen;
  logic [63:0] cfg_data = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_data;

  // pinned expectation travels with the byte being offered
  logic        pin_row = 1'b0;
  out_item_t   pin_res = '0;

  // predictor state and register mirror
  logic [3:0]  pat_len_r = 4'd1;
  logic [63:0] pat_bytes_r = '0;
  logic [3:0]  rep_len_r = 4'd1;
  logic [63:0] rep_bytes_r = '0;
  logic [7:0]  win_bytes [8];
  int unsigned win_fill = 0;

  out_item_t   step_out [$];
  out_item_t   pending_out [$];
  plan_row_t   plan [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        steady = 1'b0;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  stream_find_replace dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  function automatic int unsigned pattern_span();
    int unsigned n;
    n = pat_len_r;
    if (n == 0) n = 1;
    if (n > WinDepth) n = WinDepth;
    return n;
  endfunction

  // rewrite one text byte; results of the step land in step_out
  function automatic void rewrite_byte(in_item_t it);
    int unsigned plen;
    int unsigned rlen;
    logic        hit;
    logic [7:0]  emit [$];
    out_item_t   r;
    plen = pattern_span();
    rlen = (rep_len_r > RepDepth) ? RepDepth : rep_len_r;
    step_out.delete();
    if (win_fill >= plen) win_fill = 0;
    win_bytes[win_fill & 7] = it.in_byte;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int unsigned i = 0; i < plen; i++)
        if (win_bytes[i] != pat_bytes_r[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int unsigned i = 0; i < rlen; i++) emit.push_back(rep_bytes_r[8*i +: 8]);
        win_fill = 0;
      end else begin
        emit.push_back(win_bytes[0]);
        for (int unsigned i = 1; i < win_fill; i++) win_bytes[i-1] = win_bytes[i];
        win_fill--;
      end
    end
    if (it.in_last) begin
      for (int unsigned i = 0; i < win_fill; i++) emit.push_back(win_bytes[i]);
      win_fill = 0;
    end
    foreach (emit[i]) begin
      r.out_byte    = emit[i];
      r.run_last    = (i == emit.size() - 1);
      r.stream_last = (i == emit.size() - 1) && it.in_last;
      step_out.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(out_item_t want, out_item_t got, logic orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected transfer: byte %h run_last %b stream_last %b",
                 got.out_byte, got.run_last, got.stream_last);
      else
        $display("mismatch: expected byte %h run_last %b stream_last %b, got %h %b %b",
                 want.out_byte, want.run_last, want.stream_last,
                 got.out_byte, got.run_last, got.stream_last);
    end
  endfunction

  // predict on input transfers, check output transfers, both on pre-edge values
  always @(posedge clk) begin : scoreboard_b
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rewrite_byte(in_data);
        if (pin_row) pending_out.push_back(pin_res);
        else foreach (step_out[i]) pending_out.push_back(step_out[i]);
      end
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          note_mismatch('0, out_data, 1'b1);
        end else begin
          want = pending_out.pop_front();
          if (want.out_byte !== out_data.out_byte || want.run_last !== out_data.run_last ||
              want.stream_last !== out_data.stream_last)
            note_mismatch(want, out_data, 1'b0);
        end
      end
    end
  end

  // receiver stalls in random bursts, except in the steady phase
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void add_write(cfg_idx_e idx, logic [63:0] val);
    plan_row_t row;
    row = '{RowWrite, idx, val, '0, 1'b0, '0};
    plan.push_back(row);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic last, logic pin = 1'b0,
                                   logic [7:0] ob = '0, logic rl = 1'b0, logic sl = 1'b0);
    plan_row_t row;
    row.kind        = RowByte;
    row.reg_idx     = CfgPatternLen;
    row.value       = '0;
    row.item        = '{in_byte: b, in_last: last};
    row.pinned      = pin;
    row.result      = '{out_byte: ob, run_last: rl, stream_last: sl};
    plan.push_back(row);
  endfunction

  task automatic push_byte(in_item_t it, logic pin, out_item_t res);
    in_valid <= 1'b1;
    in_data  <= it;
    pin_row  <= pin;
    pin_res  <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    wait_drain();
    // zero-result bytes may still be in flight
    repeat (QuietCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgPatternLen: begin
        pat_len_r = val[3:0];
        win_fill  = 0;
      end
      CfgPatternBytes: pat_bytes_r = val;
      CfgReplLen:      rep_len_r = val[3:0];
      CfgReplBytes:    rep_bytes_r = val;
      default: ;
    endcase
  endtask

  function automatic logic [3:0] pick_len(int unsigned phase, logic [3:0] fixed);
    if (phase < 3) return fixed;
    if ($urandom_range(0, 2) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  initial begin : stimulus_b
    logic [7:0]  text [$];
    logic [3:0]  plen_w;
    logic [3:0]  rlen_w;
    int unsigned plen;
    int unsigned sent;
    int unsigned streams;
    int unsigned cut;
    logic        calm;
    in_item_t    it;

    // after reset: one-byte pattern 00, one-byte replacement 00
    add_byte(8'hff, 1'b0, 1'b1, 8'hff, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
    add_byte(8'h7f, 1'b1, 1'b1, 8'h7f, 1'b1, 1'b1);
    // oversized pattern length saturates, empty replacement deletes
    add_write(CfgPatternLen, 64'd15);
    add_write(CfgPatternBytes, '1);
    add_write(CfgReplLen, 64'd0);
    for (int i = 0; i < 8; i++) add_byte(8'hff, i == 7);
    // oversized replacement, partial matches slide the window
    add_write(CfgReplLen, 64'd15);
    add_write(CfgReplBytes, 64'h0123_4567_89ab_cdef);
    add_write(CfgPatternLen, 64'd3);
    add_write(CfgPatternBytes, 64'h63_6261);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h63, 1'b0);
    add_byte(8'h78, 1'b1);
    // zero pattern length acts as one
    add_write(CfgPatternLen, 64'd0);
    add_write(CfgPatternBytes, 64'h41);
    add_write(CfgReplLen, 64'd2);
    add_write(CfgReplBytes, 64'h4242);
    add_byte(8'h41, 1'b0);
    add_byte(8'h80, 1'b1, 1'b1, 8'h80, 1'b1, 1'b1);
    // rewriting the pattern length drops held bytes
    add_write(CfgPatternLen, 64'd4);
    add_write(CfgPatternBytes, 64'h6463_6261);
    add_write(CfgReplLen, 64'd1);
    add_write(CfgReplBytes, 64'h5a);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_write(CfgPatternLen, 64'd4);
    add_byte(8'h63, 1'b0);
    add_byte(8'h64, 1'b0);
    add_byte(8'h65, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        if ($urandom_range(0, 3) == 0) pause_input($urandom_range(1, 4));
        push_byte(plan[i].item, plan[i].pinned, plan[i].result);
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      plen_w = pick_len(p, (p == 0) ? 4'd1 : 4'd8);
      rlen_w = pick_len(p, (p == 0) ? 4'd8 : (p == 1) ? 4'd1 : 4'd0);
      write_reg(CfgPatternBytes, {$urandom, $urandom});
      write_reg(CfgReplBytes, {$urandom, $urandom});
      write_reg(CfgPatternLen, 64'(plen_w));
      write_reg(CfgReplLen, 64'(rlen_w));
      steady = (p == NumPhases - 1);
      plen = pattern_span();
      sent = 0;
      streams = 0;
      while (sent < PhaseItems) begin
        if (streams == 1) wait_drain();
        text.delete();
        for (int unsigned k = $urandom_range(1, 4); k != 0; k--) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              for (int unsigned j = 0; j < plen; j++) text.push_back(pat_bytes_r[8*j +: 8]);
            end
            5, 6: begin
              // pattern prefix broken by a stray byte
              cut = $urandom_range(0, plen - 1);
              for (int unsigned j = 0; j < cut; j++) text.push_back(pat_bytes_r[8*j +: 8]);
              text.push_back(8'($urandom_range(0, 255)));
            end
            7, 8: begin
              for (int unsigned j = $urandom_range(1, 3); j != 0; j--)
                text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
              for (int unsigned j = $urandom_range(1, 4); j != 0; j--)
                text.push_back(pat_bytes_r[8*$urandom_range(0, plen - 1) +: 8]);
            end
          endcase
        end
        calm = ($urandom_range(0, 3) == 0);
        foreach (text[j]) begin
          if (!steady && !calm && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 4));
          it.in_byte = text[j];
          it.in_last = (j == text.size() - 1);
          push_byte(it, 1'b0, '0);
          sent++;
        end
        streams++;
      end
    end

    wait_drain();
    repeat (2 * QuietCycles) @(posedge clk);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
